// ===== rtl/mbg_pkg.sv =====
package mbg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = $clog2(CELLS);
    localparam int DEPTH_BITS = ADDR_BITS + 1;
    localparam int CRD_BITS   = 6;
    localparam int DIM_BITS   = 7;
    localparam int WORD_BITS  = 5;

    localparam logic [WORD_BITS-1:0] BIT_N       = 5'h01;
    localparam logic [WORD_BITS-1:0] BIT_E       = 5'h02;
    localparam logic [WORD_BITS-1:0] BIT_S       = 5'h04;
    localparam logic [WORD_BITS-1:0] BIT_W       = 5'h08;
    localparam logic [WORD_BITS-1:0] BIT_VISITED = 5'h10;

    localparam logic [DIM_BITS-1:0] RST_WIDTH  = 7'd40;
    localparam logic [DIM_BITS-1:0] RST_HEIGHT = 7'd20;

    typedef enum logic [1:0] {
        MODE_RESTART = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_READ    = 2'd2,
        MODE_READ_X  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CARVED    = 3'd0,
        ST_BACKTRACK = 3'd1,
        ST_FINISHED  = 3'd2,
        ST_READ      = 3'd3,
        ST_RESTARTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } t_dir;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WAIT,
        S_PICK,
        S_WCUR,
        S_WNEW,
        S_POPST,
        S_POPCELL,
        S_RREQ,
        S_RDAT,
        S_EMIT
    } t_state;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input int maxv);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v < DIM_BITS'(2)) r = DIM_BITS'(2);
        else if (v > DIM_BITS'(maxv)) r = DIM_BITS'(maxv);
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [CRD_BITS-1:0] x,
                                                       input logic [CRD_BITS-1:0] y);
        return ADDR_BITS'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    // residue mod 3: 4 == 1 (mod 3), so base-4 digits just add up
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 8; i++) s = s + 5'(v[2*i +: 2]);
        t = 4'(s[4:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        if (u >= 3'd3) u = u - 3'd3;
        return u[1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] side_bit(input t_dir d);
        logic [WORD_BITS-1:0] r;
        unique case (d)
            DIR_N: r = BIT_N;
            DIR_E: r = BIT_E;
            DIR_S: r = BIT_S;
            DIR_W: r = BIT_W;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] back_bit(input t_dir d);
        logic [WORD_BITS-1:0] r;
        unique case (d)
            DIR_N: r = BIT_S;
            DIR_E: r = BIT_W;
            DIR_S: r = BIT_N;
            DIR_W: r = BIT_E;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/maze_backtracker_generator.sv =====
// Depth-first maze generator. Cell words (N/E/S/W passage bits, visited bit) sit in a
// single-port 4096 x 5 RAM and the path in a 4096 x 12 RAM, both with a registered read.
// Each transaction gives exactly one result. After reset the block sweeps the cell RAM
// to zero with o_in_stall high; a restart (mode 0) runs the same sweep, but writes cell
// (0,0) as visited and pushes it on the path, then gives its result. A step that carves
// makes five cell reads for the top cell and its neighbours, waits for the last read,
// picks, does two write-backs and gives the result; a step that backtracks to a
// non-empty stack makes the same reads and pick, a path RAM read, a cell RAM read and
// gives the result; a step that empties the stack goes from the pick to the result,
// and a step on a finished maze goes straight to the result. A read (mode 2 or 3)
// makes one cell read. The block then returns to idle before it takes the next one.
// A result sits in an output register, so the next transaction is taken while it
// waits on i_out_stall. Configuration writes land at once and are meant to be made
// while the block is idle; dimensions are clamped to 2..64.
module maze_backtracker_generator
    import mbg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [DIM_BITS-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [15:0]          i_random_value,
    input  logic [CRD_BITS-1:0]  i_read_x,
    input  logic [CRD_BITS-1:0]  i_read_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [CRD_BITS-1:0]  o_cell_x,
    output logic [CRD_BITS-1:0]  o_cell_y,
    output logic [1:0]           o_direction,
    output logic [WORD_BITS-1:0] o_cell_bits
);

    t_state r_state, n_state;

    // configuration
    logic [DIM_BITS-1:0] r_maze_width, r_maze_height;
    logic [DIM_BITS-1:0] w_dim, h_dim;
    logic [2*DIM_BITS-1:0] area;

    // maze control state
    logic [DEPTH_BITS-1:0] r_depth;
    logic [DEPTH_BITS-1:0] r_visited;
    logic [CRD_BITS-1:0]   r_top_x, r_top_y;
    logic [ADDR_BITS-1:0]  r_clr_addr;
    logic                  r_clr_restart;

    // per-transaction
    logic [15:0]          r_rnd;
    logic [CRD_BITS-1:0]  r_rx, r_ry;
    logic [2:0]           r_cnt;
    logic                 r_cap_en;
    logic [2:0]           r_cap_idx;
    logic [WORD_BITS-1:0] r_word [5];   // 0: top cell, 1..4: N, E, S, W
    t_dir                 r_dir;
    logic [CRD_BITS-1:0]  r_nx, r_ny;
    logic [WORD_BITS-1:0] r_new_word;

    // pending result
    logic [2:0]           r_res_status;
    logic [CRD_BITS-1:0]  r_res_x, r_res_y;
    logic [1:0]           r_res_dir;
    logic [WORD_BITS-1:0] r_res_bits;

    // output register
    logic                 r_out_valid;
    logic [2:0]           r_out_status;
    logic [CRD_BITS-1:0]  r_out_x, r_out_y;
    logic [1:0]           r_out_dir;
    logic [WORD_BITS-1:0] r_out_bits;

    // RAM ports
    logic                  cell_we;
    logic [ADDR_BITS-1:0]  cell_addr_q;
    logic [WORD_BITS-1:0]  cell_wdata, cell_rdata;
    logic                  stk_we;
    logic [ADDR_BITS-1:0]  stk_addr;
    logic [2*CRD_BITS-1:0] stk_wdata, stk_rdata;

    logic in_acc, out_free, finished, clr_last;
    logic [3:0] nb_ok, avail;
    logic [2:0] n_avail;
    logic [1:0] sel, kth;
    t_dir       pick_dir;
    logic       carve;

    mbg_ram #(.WIDTH(WORD_BITS), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_addr  (cell_addr_q),
        .i_wdata (cell_wdata),
        .o_rdata (cell_rdata)
    );

    mbg_ram #(.WIDTH(2*CRD_BITS), .DEPTH(CELLS)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_addr  (stk_addr),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    assign w_dim    = clamp_dim(r_maze_width, MAX_WIDTH);
    assign h_dim    = clamp_dim(r_maze_height, MAX_HEIGHT);
    assign area     = w_dim * h_dim;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = (r_clr_addr == ADDR_BITS'(CELLS - 1));
    assign finished = (r_depth == '0) || ({1'b0, r_visited} >= area);

    // neighbours in range: N, E, S, W
    always_comb begin
        nb_ok[0] = (r_top_y != '0);
        nb_ok[1] = ({1'b0, r_top_x} + DIM_BITS'(1)) < w_dim;
        nb_ok[2] = ({1'b0, r_top_y} + DIM_BITS'(1)) < h_dim;
        nb_ok[3] = (r_top_x != '0);
        for (int d = 0; d < 4; d++) begin
            avail[d] = nb_ok[d] && !r_word[d+1][4];
        end
        n_avail = 3'($countones(avail));
    end

    // random_value mod list length, then the sel-th open neighbour
    always_comb begin
        logic [1:0] k;
        sel = '0;
        unique case (n_avail)
            3'd2:    sel = {1'b0, r_rnd[0]};
            3'd3:    sel = mod3(r_rnd);
            3'd4:    sel = r_rnd[1:0];
            default: sel = '0;
        endcase
        k = '0;
        kth = '0;
        for (int d = 3; d >= 0; d--) begin
            if (avail[d]) kth = 2'(d);
        end
        for (int d = 0; d < 4; d++) begin
            if (avail[d]) begin
                if (k == sel) kth = 2'(d);
                k = k + 2'd1;
            end
        end
        pick_dir = t_dir'(kth);
        carve    = (n_avail != '0) && (r_depth < DEPTH_BITS'(CELLS));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = r_clr_restart ? S_EMIT : S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_mode'(i_mode))
                        MODE_RESTART: n_state = S_CLEAR;
                        MODE_STEP:    n_state = finished ? S_EMIT : S_RD;
                        MODE_READ,
                        MODE_READ_X:  n_state = S_RREQ;
                    endcase
                end
            end
            S_RD:      if (r_cnt == 3'd4) n_state = S_WAIT;
            S_WAIT:    n_state = S_PICK;
            S_PICK: begin
                if (carve) n_state = S_WCUR;
                else if (r_depth == DEPTH_BITS'(1)) n_state = S_EMIT;
                else n_state = S_POPST;
            end
            S_WCUR:    n_state = S_WNEW;
            S_WNEW:    n_state = S_EMIT;
            S_POPST:   n_state = S_POPCELL;
            S_POPCELL: n_state = S_EMIT;
            S_RREQ:    n_state = S_RDAT;
            S_RDAT:    n_state = S_EMIT;
            S_EMIT:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        cell_we     = 1'b0;
        cell_addr_q = cell_addr(r_top_x, r_top_y);
        cell_wdata  = '0;
        stk_we      = 1'b0;
        stk_addr    = r_depth[ADDR_BITS-1:0];
        stk_wdata   = {r_ny, r_nx};
        o_in_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                cell_we     = 1'b1;
                cell_addr_q = r_clr_addr;
                cell_wdata  = (r_clr_restart && r_clr_addr == '0) ? BIT_VISITED : '0;
                stk_we      = r_clr_restart && (r_clr_addr == '0);
                stk_addr    = '0;
                stk_wdata   = '0;
            end
            S_RD: begin
                unique case (r_cnt)
                    3'd1:    cell_addr_q = cell_addr(r_top_x, r_top_y - CRD_BITS'(1));
                    3'd2:    cell_addr_q = cell_addr(r_top_x + CRD_BITS'(1), r_top_y);
                    3'd3:    cell_addr_q = cell_addr(r_top_x, r_top_y + CRD_BITS'(1));
                    3'd4:    cell_addr_q = cell_addr(r_top_x - CRD_BITS'(1), r_top_y);
                    default: cell_addr_q = cell_addr(r_top_x, r_top_y);
                endcase
            end
            S_PICK: begin
                stk_addr = ADDR_BITS'(r_depth - DEPTH_BITS'(2));
            end
            S_WCUR: begin
                cell_we    = 1'b1;
                cell_wdata = r_word[0] | side_bit(r_dir);
            end
            S_WNEW: begin
                cell_we     = 1'b1;
                cell_addr_q = cell_addr(r_nx, r_ny);
                cell_wdata  = r_new_word;
                stk_we      = 1'b1;
            end
            S_POPST: begin
                cell_addr_q = cell_addr(stk_rdata[CRD_BITS-1:0],
                                        stk_rdata[2*CRD_BITS-1:CRD_BITS]);
            end
            S_RREQ: begin
                cell_addr_q = cell_addr(r_rx, r_ry);
            end
            default: begin
                cell_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_maze_width  <= RST_WIDTH;
            r_maze_height <= RST_HEIGHT;
            r_depth       <= '0;
            r_visited     <= '0;
            r_clr_addr    <= '0;
            r_clr_restart <= 1'b0;
            r_cap_en      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:  r_maze_width  <= i_cfg_data;
                    CFG_HEIGHT: r_maze_height <= i_cfg_data;
                endcase
            end

            // top-cell and neighbour words come back in the cycle after their address
            r_cap_en  <= (r_state == S_RD);
            r_cap_idx <= r_cnt;
            if (r_cap_en) r_word[r_cap_idx] <= cell_rdata;

            // load a new result, or drop the one taken downstream
            if (r_state == S_EMIT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
                    if (clr_last && r_clr_restart) begin
                        r_depth      <= DEPTH_BITS'(1);
                        r_visited    <= DEPTH_BITS'(1);
                        r_top_x      <= '0;
                        r_top_y      <= '0;
                        r_res_status <= ST_RESTARTED;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_dir    <= DIR_N;
                        r_res_bits   <= BIT_VISITED;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        r_rnd <= i_random_value;
                        r_rx  <= i_read_x;
                        r_ry  <= i_read_y;
                        if (t_mode'(i_mode) == MODE_RESTART) begin
                            r_clr_restart <= 1'b1;
                            r_clr_addr    <= '0;
                        end
                        r_res_status <= ST_FINISHED;
                        r_res_x      <= '0;
                        r_res_y      <= '0;
                        r_res_dir    <= DIR_N;
                        r_res_bits   <= '0;
                    end
                end
                S_RD: r_cnt <= r_cnt + 3'd1;
                S_PICK: begin
                    r_dir      <= pick_dir;
                    r_new_word <= r_word[3'(pick_dir) + 3'd1] | back_bit(pick_dir)
                                  | BIT_VISITED;
                    unique case (pick_dir)
                        DIR_N: begin
                            r_nx <= r_top_x;
                            r_ny <= r_top_y - CRD_BITS'(1);
                        end
                        DIR_E: begin
                            r_nx <= r_top_x + CRD_BITS'(1);
                            r_ny <= r_top_y;
                        end
                        DIR_S: begin
                            r_nx <= r_top_x;
                            r_ny <= r_top_y + CRD_BITS'(1);
                        end
                        DIR_W: begin
                            r_nx <= r_top_x - CRD_BITS'(1);
                            r_ny <= r_top_y;
                        end
                    endcase
                    if (!carve) begin
                        r_depth      <= r_depth - DEPTH_BITS'(1);
                        r_res_status <= ST_BACKTRACK;
                    end
                end
                S_WNEW: begin
                    r_depth      <= r_depth + DEPTH_BITS'(1);
                    r_visited    <= r_visited + DEPTH_BITS'(1);
                    r_top_x      <= r_nx;
                    r_top_y      <= r_ny;
                    r_res_status <= ST_CARVED;
                    r_res_x      <= r_nx;
                    r_res_y      <= r_ny;
                    r_res_dir    <= r_dir;
                    r_res_bits   <= r_new_word;
                end
                S_POPST: begin
                    r_top_x <= stk_rdata[CRD_BITS-1:0];
                    r_top_y <= stk_rdata[2*CRD_BITS-1:CRD_BITS];
                end
                S_POPCELL: begin
                    r_res_x    <= r_top_x;
                    r_res_y    <= r_top_y;
                    r_res_bits <= cell_rdata;
                end
                S_RDAT: begin
                    r_res_status <= ST_READ;
                    r_res_x      <= r_rx;
                    r_res_y      <= r_ry;
                    r_res_bits   <= cell_rdata;
                end
                S_EMIT: begin
                    r_clr_restart <= 1'b0;
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_x      <= r_res_x;
                        r_out_y      <= r_res_y;
                        r_out_dir    <= r_res_dir;
                        r_out_bits   <= r_res_bits;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_direction = r_out_dir;
    assign o_cell_bits = r_out_bits;

`ifndef ASSERT_OFF
    // every cell on the path has been visited once
    a_depth_le_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_visited)
        else $error("stack deeper than visited count");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_BITS'(CELLS))
        else $error("stack overflow");

    // a carve never lands on a visited cell
    a_carve_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) && carve |-> !r_word[3'(pick_dir) + 3'd1][4])
        else $error("carving into a visited cell");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result without a completed transaction");
`endif

endmodule

// ===== rtl/mbg_ram.sv =====
module mbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
